### rtl/core/ansi_color_escape_decoder_core_macros.svh
// ---------------------------------------------------------------------------
// ANSI color decoder assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ANSI_COLOR_ESCAPE_DECODER_CORE_MACROS_SVH
`define ANSI_COLOR_ESCAPE_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ACD_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("acd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ACD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("acd assertion failed");

`else

`define ACD_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define ACD_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

### rtl/core/acd_pkg.sv
// ---------------------------------------------------------------------------
// acd_pkg
// Shared constants, types and digit decoders of the ANSI color decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package acd_pkg;

    // Sequence buffer depth default
    localparam int SEQ_MAX_BYTES_DEF = 11;

    // Control and sequence characters
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_ENABLE = 2'd2;

    // Register reset values
    localparam logic [3:0] RST_DEFAULT_FG  = 4'd7;
    localparam logic [3:0] RST_DEFAULT_BG  = 4'd0;
    localparam logic       RST_BEEP_ENABLE = 1'b1;

    // Result kinds
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_BEEP = 1'b1;

    typedef struct packed {
        logic [3:0] fg;
        logic [3:0] bg;
    } color_pair_t;

    // Anything but '0' counts as bright.
    function automatic logic bright_of(input logic [7:0] c);
        return (c != CH_ZERO);
    endfunction

    // '0'..'7' map to 0..7, anything else to 7.
    function automatic logic [2:0] color_of(input logic [7:0] c);
        return ((c >= CH_ZERO) && (c <= CH_SEVEN)) ? c[2:0] : 3'd7;
    endfunction

    function automatic logic [3:0] pal(input logic [7:0] b, input logic [7:0] c);
        return {bright_of(b), color_of(c)};
    endfunction

    // Six-byte form: t1 bright/reverse field, t3 plane select, t4 color digit.
    function automatic color_pair_t rule_six(
        input logic [7:0]  t1,
        input logic [7:0]  t3,
        input logic [7:0]  t4,
        input color_pair_t cur,
        input logic [3:0]  dfg
    );
        color_pair_t res;
        res = cur;
        if ((t1 == CH_ZERO) || (t1 == CH_ONE)) begin
            if (t3 == CH_THREE) begin
                res.fg = pal(t1, t4);
            end else if (t3 == CH_FOUR) begin
                res.bg = pal(t1, t4);
            end
        end else if (t1 == CH_SEVEN) begin
            res.fg = 4'd0;
            res.bg = {1'b1, color_of(t4)};
        end else begin
            res.fg = dfg;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/acd_ifs.sv
// ---------------------------------------------------------------------------
// acd channel interfaces
// Valid/ready channels for text input, decoded output and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface acd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       block_start;

    modport source (output valid, output in_byte, output block_start, input ready);
    modport sink   (input valid, input in_byte, input block_start, output ready);
endinterface

interface acd_tx_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] text_byte;
    logic [3:0] fg_index;
    logic [3:0] bg_index;

    modport source (output valid, output kind, output text_byte, output fg_index,
                    output bg_index, input ready);
    modport sink   (input valid, input kind, input text_byte, input fg_index,
                    input bg_index, output ready);
endinterface

interface acd_cfg_if import acd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/acd_rules.sv
// ---------------------------------------------------------------------------
// acd_rules
// Fixed-position SGR rules: new colors from a buffered sequence and length.
// ---------------------------------------------------------------------------
`default_nettype none

module acd_rules
    import acd_pkg::*;
#(
    parameter int SEQ_MAX_BYTES = SEQ_MAX_BYTES_DEF,
    parameter int LEN_W         = $clog2(SEQ_MAX_BYTES + 1)
)(
    input  wire logic [7:0]       seq_buf [SEQ_MAX_BYTES],
    input  wire logic [LEN_W-1:0] seq_len,     // bytes after ESC, closing 'm' included
    input  wire color_pair_t      cur,
    input  wire color_pair_t      defaults,
    output color_pair_t           upd
);

    always_comb
    begin
        upd = cur;
        unique case (seq_len)
            LEN_W'(2):
            begin
                upd.fg = defaults.fg;
                if (seq_buf[0] == CH_LBRK)
                begin
                    upd.bg = defaults.bg;
                end
            end
            LEN_W'(3):
            begin
                upd.fg = ((seq_buf[0] == CH_LBRK) && (seq_buf[1] == CH_ONE))
                       ? 4'd15 : defaults.fg;
            end
            LEN_W'(4):
            begin
                if (seq_buf[1] == CH_THREE)
                    upd.fg = {1'b0, color_of(seq_buf[2])};
                else if (seq_buf[1] == CH_FOUR)
                    upd.bg = {1'b0, color_of(seq_buf[2])};
                else
                    upd.fg = defaults.fg;
            end
            LEN_W'(6):
            begin
                upd = rule_six(seq_buf[1], seq_buf[3], seq_buf[4], cur, defaults.fg);
            end
            LEN_W'(7):
            begin
                // same form, shifted by one past a leading ';'
                if (seq_buf[1] == CH_SEMI)
                    upd = rule_six(seq_buf[2], seq_buf[4], seq_buf[5], cur, defaults.fg);
                else
                    upd.fg = defaults.fg;
            end
            LEN_W'(8):
            begin
                upd.fg = (seq_buf[5] == CH_THREE) ? pal(seq_buf[3], seq_buf[6])
                                                  : defaults.fg;
            end
            LEN_W'(9):
            begin
                if (seq_buf[3] == CH_FOUR)
                    upd.bg = (seq_buf[4] == CH_ZERO) ? 4'd0
                                                     : {1'b1, color_of(seq_buf[4])};
                if (seq_buf[6] == CH_THREE)
                    upd.fg = pal(seq_buf[1], seq_buf[7]);
            end
            LEN_W'(11):
            begin
                if (seq_buf[3] == CH_FOUR)
                    upd.bg = ((seq_buf[1] == CH_ONE) && (seq_buf[4] == CH_ZERO))
                           ? 4'd0 : pal(seq_buf[1], seq_buf[4]);
                if (seq_buf[8] == CH_THREE)
                    upd.fg = pal(seq_buf[6], seq_buf[9]);
            end
            default:
            begin
                upd.fg = defaults.fg;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/ansi_color_escape_decoder_core.sv
// ---------------------------------------------------------------------------
// ansi_color_escape_decoder_core
// Terminal text decoder: tags text bytes with SGR fg/bg palette indices.
// ---------------------------------------------------------------------------
//
//  port | role   | word                                          | accepted when
//  -----+--------+-----------------------------------------------+---------------------
//  rx   | sink   | in_byte[7:0], block_start                     | rx.valid & rx.ready
//  tx   | source | kind, text_byte[7:0], fg_index[3:0], bg_index | tx.valid & tx.ready
//  cfg  | sink   | index[1:0], data[3:0] (always ready)          | cfg.valid & cfg.ready
//
//  One word per cycle sustained unless a stalled tx holds back a result: a
//  word lands in the input register, is decoded against the escape state
//  and current colors, and any result lands in the output register.
//  The loop through the escape state and color registers sets the rate.
//  A stalled tx holds only words with a result; CR, ESC, in-sequence bytes and
//  muted BEL still drain. Async active-low reset loads defaults, not the buffer.
//
`default_nettype none

`include "ansi_color_escape_decoder_core_macros.svh"

module ansi_color_escape_decoder_core
    import acd_pkg::*;
#(
    parameter int SEQ_MAX_BYTES = SEQ_MAX_BYTES_DEF
)(
    input wire logic  clk,
    input wire logic  rst_n,
    acd_rx_if.sink    rx,
    acd_tx_if.source  tx,
    acd_cfg_if.sink   cfg
);

    localparam int LEN_W = $clog2(SEQ_MAX_BYTES + 1);
    localparam int IDX_W = $clog2(SEQ_MAX_BYTES);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(SEQ_MAX_BYTES);

    // ---------------- configuration registers ----------------
    color_pair_t dflt_reg;
    logic        beep_en_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_reg.fg <= RST_DEFAULT_FG;
            dflt_reg.bg <= RST_DEFAULT_BG;
            beep_en_reg <= RST_BEEP_ENABLE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DEFAULT_FG:  dflt_reg.fg <= cfg.data;
                CFG_DEFAULT_BG:  dflt_reg.bg <= cfg.data;
                CFG_BEEP_ENABLE: beep_en_reg <= cfg.data[0];
                default:         ;  // unmapped index: drop the write
            endcase
        end
    end

    // ---------------- input register ----------------
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;
    logic       rx_fire;
    logic       proc_go;

    assign rx.ready = !s1_valid_reg || proc_go;
    assign rx_fire  = rx.valid && rx.ready;

    always_comb
    begin
        priority if (rx_fire)
            s1_valid_next = 1'b1;
        else if (proc_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            s1_byte_reg  <= rx.in_byte;
            s1_start_reg <= rx.block_start;
        end
    end

    // ---------------- decode state ----------------
    logic             esc_reg, esc_next;
    logic [LEN_W-1:0] len_reg, len_next;
    color_pair_t      color_reg, color_next;
    logic [7:0]       seq_buf [SEQ_MAX_BYTES];
    logic             buf_wr;

    color_pair_t      rule_upd;
    logic [LEN_W-1:0] rule_len;

    // length of the sequence including the closing 'm'
    assign rule_len = len_reg + LEN_W'(1);

    acd_rules #(
        .SEQ_MAX_BYTES (SEQ_MAX_BYTES),
        .LEN_W         (LEN_W)
    ) u_rules (
        .seq_buf  (seq_buf),
        .seq_len  (rule_len),
        .cur      (color_reg),
        .defaults (dflt_reg),
        .upd      (rule_upd)
    );

    // ---------------- decode logic ----------------
    logic        res_valid;
    logic        res_kind;
    logic [7:0]  res_byte;
    color_pair_t res_color;
    color_pair_t base_color;
    logic        len_room;

    assign len_room   = (len_reg < LEN_MAX);
    // block start outside a sequence falls back to the defaults first
    assign base_color = s1_start_reg ? dflt_reg : color_reg;

    always_comb
    begin
        esc_next   = esc_reg;
        len_next   = len_reg;
        color_next = color_reg;
        buf_wr     = 1'b0;
        res_valid  = 1'b0;
        res_kind   = KIND_TEXT;
        res_byte   = s1_byte_reg;
        res_color  = base_color;

        if (esc_reg)
        begin
            if (s1_byte_reg == CH_M)
            begin
                // close the sequence; an overlong one is dropped whole
                if (len_room)
                    color_next = rule_upd;
                esc_next = 1'b0;
                len_next = '0;
            end
            else if (len_room)
            begin
                buf_wr   = 1'b1;
                len_next = len_reg + LEN_W'(1);
            end
        end
        else
        begin
            color_next = base_color;
            priority if (s1_byte_reg == CH_CR)
            begin
                res_valid = 1'b0;
            end
            else if (s1_byte_reg == CH_BEL)
            begin
                res_valid = beep_en_reg;
                res_kind  = KIND_BEEP;
                res_byte  = 8'd0;
                res_color = '0;
            end
            else if (s1_byte_reg == CH_ESC)
            begin
                esc_next = 1'b1;
                len_next = '0;
            end
            else
            begin
                res_valid = 1'b1;
            end
        end
    end

    // advance unless a result would overwrite an untaken one
    assign proc_go = s1_valid_reg && (!res_valid || !tx.valid || tx.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg      <= 1'b0;
            len_reg      <= '0;
            color_reg.fg <= RST_DEFAULT_FG;
            color_reg.bg <= RST_DEFAULT_BG;
        end
        else if (proc_go)
        begin
            esc_reg   <= esc_next;
            len_reg   <= len_next;
            color_reg <= color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && buf_wr)
            seq_buf[len_reg[IDX_W-1:0]] <= s1_byte_reg;
    end

    // ---------------- output register ----------------
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg;
    logic [7:0]  out_byte_reg;
    color_pair_t out_color_reg;
    logic        out_load;

    assign out_load = proc_go && res_valid;

    always_comb
    begin
        priority if (out_load)
            out_valid_next = 1'b1;
        else if (tx.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg  <= res_kind;
            out_byte_reg  <= res_byte;
            out_color_reg <= res_color;
        end
    end

    assign tx.valid     = out_valid_reg;
    assign tx.kind      = out_kind_reg;
    assign tx.text_byte = out_byte_reg;
    assign tx.fg_index  = out_color_reg.fg;
    assign tx.bg_index  = out_color_reg.bg;

    // ---------------- assertions ----------------
    `ACD_ASSERT_IMPL(a_len_bound, clk, rst_n, 1'b1, len_reg <= LEN_MAX)
    `ACD_ASSERT_IMPL(a_len_idle, clk, rst_n, !esc_reg, len_reg == '0)
    `ACD_ASSERT_IMPL(a_beep_zero, clk, rst_n,
        out_valid_reg && (out_kind_reg == KIND_BEEP),
        (out_byte_reg == 8'd0) && (out_color_reg == '0))
    `ACD_ASSERT_NEXT(a_hold_word, clk, rst_n, s1_valid_reg && !proc_go,
        s1_valid_reg && (s1_byte_reg == $past(s1_byte_reg)))

endmodule

`default_nettype wire
